FILE: src/f2dt_pkg.sv
`default_nettype none
package f2dt_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;

  localparam logic [3:0] PLACES_RESET = 4'd6;
  localparam logic [3:0] FRAC_DIGITS  = 4'd9;

  // classified item handed from front to back
  typedef struct packed {
    logic        neg;
    logic        inf;
    logic [31:0] ipart;
    logic [31:0] fpart;
  } item_t;

  function automatic logic [6:0] inf_char(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0: c = 7'h49;
      3'd1: c = 7'h6E;
      3'd2: c = 7'h66;
      3'd3: c = 7'h69;
      3'd4: c = 7'h6E;
      3'd5: c = 7'h69;
      3'd6: c = 7'h74;
      3'd7: c = 7'h79;
      default: c = 7'h79;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/f2dt_front.sv
`default_nettype none
// splits the float into integer and fraction words and queues the item
module f2dt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        float_bits_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    avail_o,
  output f2dt_pkg::item_t         item_o
);

  f2dt_pkg::item_t  mem_q [f2dt_pkg::QDEPTH];
  logic [f2dt_pkg::QAW-1:0] wp_q, rp_q;
  logic [f2dt_pkg::QAW:0]   cnt_q;
  f2dt_pkg::item_t  cls;
  logic [7:0]       rexp;
  logic [63:0]      pair, shl, shr;
  logic             push;

  always_comb begin
    rexp = float_bits_i[30:23];
    pair = {32'd1, float_bits_i[22:0], 9'd0};
    shl  = pair << (rexp - 8'd127);
    shr  = pair >> (8'd127 - rexp);
    cls.neg = float_bits_i[31];
    cls.inf = (rexp == 8'hFF);
    if (rexp >= 8'd127) begin
      cls.ipart = shl[63:32];
      cls.fpart = shl[31:0];
    end else begin
      cls.ipart = shr[63:32];
      cls.fpart = shr[31:0];
    end
  end

  assign full_o  = (cnt_q == (f2dt_pkg::QAW+1)'(f2dt_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign push    = start_i && !full_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (f2dt_pkg::QAW+1)'(push) - (f2dt_pkg::QAW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: src/f2dt_back.sv
`default_nettype none
// sequencer: sign, integer digits, point, fraction digits (or Infinity), one char per cycle while emitting
module f2dt_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [3:0]         places_i,
  input  wire logic               avail_i,
  input  wire f2dt_pkg::item_t    item_i,
  output logic                    pop_o,
  output logic                    valid_o,
  output logic [6:0]              character_o,
  output logic                    last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_DOT  = 3'd4;
  localparam logic [2:0] S_FRAC = 3'd5;
  localparam logic [2:0] S_INF  = 3'd6;

  logic [2:0]  st_q, st_d;
  logic        neg_q, inf_q;
  logic [31:0] ip_q, fp_q;
  logic [29:0] frac_q;
  logic [4:0]  bit_q;
  logic [39:0] dig_q;
  logic [3:0]  nd_q;
  logic [3:0]  k_q;
  logic [3:0]  left_q;
  logic [2:0]  ii_q;
  logic [35:0] fdig_q;
  logic [3:0]  fk_q;
  logic        rnd_q;
  logic [3:0]  d;
  logic [31:0] q;
  logic [33:0] qm;
  logic [3:0]  fd;
  logic        rend;
  logic [3:0]  fq;
  logic [29:0] fsub, frem, fnext;

  // ip/10 by reciprocal multiply, and the remainder digit
  always_comb begin
    qm = 34'(({32'd0, ip_q} * 64'hCCCCCCCD) >> 35);
    q  = qm[31:0];
    d  = 4'(ip_q - q * 32'd10);
  end

  // next fraction digit by compare against multiples of 1e8, rest times ten
  always_comb begin
    fq   = 4'd0;
    fsub = 30'd0;
    for (int k = 1; k <= 9; k++) begin
      if (frac_q >= 30'(k * 100000000)) begin
        fq   = 4'(k);
        fsub = 30'(k * 100000000);
      end
    end
    frem  = frac_q - fsub;
    fnext = (frem << 3) + (frem << 1);
  end

  always_comb begin
    fd   = fdig_q[35:32];
    rend = (left_q == 4'd1) && (places_i < f2dt_pkg::FRAC_DIGITS);
  end

  assign pop_o = (st_q == S_IDLE) && avail_i;

  always_comb begin
    st_d        = st_q;
    valid_o     = 1'b0;
    character_o = f2dt_pkg::CH_ZERO;
    last_o      = 1'b0;
    case (st_q)
      S_IDLE: if (avail_i) st_d = S_CONV;
      S_CONV: begin
        if (bit_q == 5'd31 && fk_q == 4'd9 &&
            (nd_q != 0 && ip_q == 0 || nd_q == 4'd10)) st_d = S_SIGN;
      end
      S_SIGN: begin
        if (neg_q) begin
          valid_o = 1'b1;
          character_o = f2dt_pkg::CH_MINUS;
        end
        st_d = inf_q ? S_INF : S_INT;
      end
      S_INF: begin
        valid_o = 1'b1;
        character_o = f2dt_pkg::inf_char(ii_q);
        last_o = (ii_q == 3'd7);
        if (ii_q == 3'd7) st_d = S_IDLE;
      end
      S_INT: begin
        valid_o = 1'b1;
        character_o = f2dt_pkg::CH_ZERO + 7'(dig_q[4*k_q +: 4]);
        if (k_q == 4'd0) st_d = S_DOT;
      end
      S_DOT: begin
        valid_o = 1'b1;
        character_o = f2dt_pkg::CH_DOT;
        last_o = (places_i == 4'd0);
        st_d = (places_i == 4'd0) ? S_IDLE : S_FRAC;
      end
      S_FRAC: begin
        valid_o = 1'b1;
        character_o = f2dt_pkg::CH_ZERO + 7'(fd)
                      + 7'(rend && rnd_q && fd < 4'd9);
        last_o = (left_q == 4'd1);
        if (left_q == 4'd1) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        neg_q <= item_i.neg;
        inf_q <= item_i.inf;
        ip_q <= item_i.ipart;
        fp_q <= item_i.fpart;
        frac_q <= '0;
        bit_q <= '0;
        nd_q <= '0;
        ii_q <= '0;
        fk_q <= '0;
        left_q <= (places_i > f2dt_pkg::FRAC_DIGITS) ? f2dt_pkg::FRAC_DIGITS : places_i;
      end
      S_CONV: begin
        if (bit_q != 5'd31) begin
          if (fp_q[31]) frac_q <= frac_q + 30'(32'd1000000000 >> (bit_q + 5'd1));
          fp_q <= fp_q << 1;
          bit_q <= bit_q + 5'd1;
        end else if (fk_q != 4'd9) begin
          // fraction digits, most significant first, one per cycle
          fdig_q <= {fdig_q[31:0], fq};
          frac_q <= fnext;
          fk_q <= fk_q + 4'd1;
        end
        if (!(nd_q != 0 && ip_q == 0) && nd_q != 4'd10) begin
          dig_q[4*nd_q +: 4] <= d;
          ip_q <= q;
          nd_q <= nd_q + 4'd1;
        end
        k_q <= nd_q - 4'd1;
      end
      S_SIGN: k_q <= nd_q - 4'd1;
      S_INT: k_q <= k_q - 4'd1;
      S_INF: ii_q <= ii_q + 3'd1;
      S_FRAC: begin
        fdig_q <= fdig_q << 4;
        left_q <= left_q - 4'd1;
      end
      default: ;
    endcase
    if (st_q == S_FRAC || st_q == S_DOT) begin
      rnd_q <= (st_q == S_DOT) ? 1'b0 : 1'b0;
    end
    if (st_q == S_FRAC && left_q == 4'd2) rnd_q <= fdig_q[27:24] > 4'd4;
    if (st_q == S_DOT && left_q == 4'd1) rnd_q <= fdig_q[31:28] > 4'd4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/float_to_decimal_text.sv
// float to decimal ascii text, one character per cycle on character_o while strobe is high
// after the accepting edge the sequencer runs the fraction sum steps, then
// the fraction digit steps, then the sign step, before the first digit
// a new number leaves the queue only after the last character of the one before
// the receiver cannot stall: each character transfer lasts one strobe cycle
// reset: async active low, clears queue and sequencer, round_places to 6
`default_nettype none
module float_to_decimal_text (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] float_bits_i,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  round_places_i,
  output logic             strobe,
  output logic [6:0]       character_o,
  output logic             last_o
);

  logic [3:0]      places_q;
  logic            pop, avail, full;
  f2dt_pkg::item_t item;

  // places register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      places_q <= f2dt_pkg::PLACES_RESET;
    end else if (cfg_we_i) begin
      places_q <= round_places_i;
    end
  end

  assign busy = full;

  // front: classify and queue
  f2dt_front u_front (
    .clk_i, .rst_ni,
    .start_i(start), .float_bits_i,
    .full_o(full), .pop_i(pop), .avail_o(avail), .item_o(item)
  );

  // back: emit text
  f2dt_back u_back (
    .clk_i, .rst_ni,
    .places_i(places_q), .avail_i(avail), .item_i(item), .pop_o(pop),
    .valid_o(strobe), .character_o, .last_o
  );

endmodule
`default_nettype wire
